/* hdl/efpf_pkg.sv */
// ----------------------------------------------------------------------------
// Ethernet FCS pad framer package
// Shared constants, result kind codes and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efpf_pkg;

  localparam logic [31:0] FCS_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [5:0]  MIN_FRAME  = 6'd60;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_FCS  = 2'd2
  } kind_t;

  // Reflected CRC-32 folded over one byte, least significant bit first.
  function automatic logic [31:0] fcs_fold(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (FCS_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

/* hdl/ethernet_fcs_pad_framer.sv */
// ----------------------------------------------------------------------------
// Ethernet FCS pad framer
// Passes frame bytes through, zero-pads each frame to at least 60 bytes and a
// multiple of 4, and appends the CRC-32 frame check sequence, low byte first.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one frame byte per request, with in_last set on
// the final byte. The output channel carries one byte per request, tagged as
// frame data, zero pad or check sequence; out_last marks the fourth check byte.
// Each accepted input byte is registered in the output register, or in the
// skid register while a result waits. Unless the receiver stalls, a frame and
// its tail stream at one byte per cycle. After the final byte the block stops
// taking input while it emits the pad (up to 59 bytes, to 60 bytes and then a
// multiple of 4) and four check bytes; that tail sets the gap between frames.
// A two-entry output buffer (output register plus skid register) keeps the
// block taking input while a result waits; in_stall is driven from registers
// only. When the receiver stalls, the buffer fills and in_stall rises after
// one more request. A synchronous reset empties the buffer and presets the
// CRC to all ones, ready for the first byte of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ethernet_fcs_pad_framer
  import efpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);

  typedef enum logic [2:0] {
    ST_DATA = 3'b001,
    ST_PAD  = 3'b010,
    ST_FCS  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  pad_left_r, pad_left_nxt;
  logic [1:0]  fcs_idx_r, fcs_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic        out_last_r, out_last_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [7:0]  skid_byte_r, skid_byte_nxt;
  kind_t       skid_kind_r, skid_kind_nxt;
  logic        skid_last_r, skid_last_nxt;

  logic        in_accept;
  logic        out_take;
  logic        push_vld;
  logic [7:0]  push_byte;
  kind_t       push_kind;
  logic        push_last;
  logic [5:0]  cnt_inc;
  logic [1:0]  phase_inc;
  logic [5:0]  pad_len;
  logic [31:0] fcs;
  logic [7:0]  fcs_byte;

  assign in_stall  = skid_valid_r || (state_r != ST_DATA);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  assign cnt_inc   = (cnt_r < MIN_FRAME) ? cnt_r + 6'd1 : cnt_r;
  assign phase_inc = phase_r + 2'd1;
  // Short frames pad up to the minimum, which is already a multiple of four.
  assign pad_len   = (cnt_inc < MIN_FRAME) ? MIN_FRAME - cnt_inc
                                           : {4'd0, 2'd0 - phase_inc};
  assign fcs       = ~crc_r;
  assign fcs_byte  = 8'(fcs >> {fcs_idx_r, 3'b000});

  // Result producer and frame state.
  always_comb begin
    state_nxt    = state_r;
    crc_nxt      = crc_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    pad_left_nxt = pad_left_r;
    fcs_idx_nxt  = fcs_idx_r;
    push_vld     = 1'b0;
    push_byte    = in_byte;
    push_kind    = KIND_DATA;
    push_last    = 1'b0;
    case (state_r)
      ST_DATA: begin
        push_vld = in_accept;
        if (in_accept) begin
          crc_nxt   = fcs_fold(crc_r, in_byte);
          cnt_nxt   = cnt_inc;
          phase_nxt = phase_inc;
          if (in_last) begin
            cnt_nxt      = 6'd0;
            phase_nxt    = 2'd0;
            pad_left_nxt = pad_len;
            fcs_idx_nxt  = 2'd0;
            state_nxt    = (pad_len == 6'd0) ? ST_FCS : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_vld  = !skid_valid_r;
        push_byte = 8'd0;
        push_kind = KIND_PAD;
        if (push_vld) begin
          crc_nxt      = fcs_fold(crc_r, 8'd0);
          pad_left_nxt = pad_left_r - 6'd1;
          if (pad_left_r == 6'd1) begin
            state_nxt = ST_FCS;
          end
        end
      end
      ST_FCS: begin
        push_vld  = !skid_valid_r;
        push_byte = fcs_byte;
        push_kind = KIND_FCS;
        push_last = (fcs_idx_r == 2'd3);
        if (push_vld) begin
          fcs_idx_nxt = fcs_idx_r + 2'd1;
          if (fcs_idx_r == 2'd3) begin
            crc_nxt   = CRC_PRESET;
            state_nxt = ST_DATA;
          end
        end
      end
      default: begin
        state_nxt = ST_DATA;
        crc_nxt   = CRC_PRESET;
      end
    endcase
  end

  // Output register with a skid register behind it. The producer pushes only
  // while the skid register is empty.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_byte_nxt  = skid_byte_r;
    skid_kind_nxt  = skid_kind_r;
    skid_last_nxt  = skid_last_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = skid_byte_r;
        out_kind_nxt   = skid_kind_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_vld;
        out_byte_nxt  = push_byte;
        out_kind_nxt  = push_kind;
        out_last_nxt  = push_last;
      end
    end else if (push_vld) begin
      skid_valid_nxt = 1'b1;
      skid_byte_nxt  = push_byte;
      skid_kind_nxt  = push_kind;
      skid_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_DATA;
      crc_r        <= CRC_PRESET;
      cnt_r        <= 6'd0;
      phase_r      <= 2'd0;
      pad_left_r   <= 6'd0;
      fcs_idx_r    <= 2'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      crc_r        <= crc_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
      pad_left_r   <= pad_left_nxt;
      fcs_idx_r    <= fcs_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    skid_byte_r <= skid_byte_nxt;
    skid_kind_r <= skid_kind_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

/* hdl/efpf_checker.sv */
// ----------------------------------------------------------------------------
// Ethernet FCS pad framer checker
// Port-level assertions on the framer's output sequencing and flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efpf_checker
  import efpf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // The frame end flag may only ride on a check sequence byte.
  a_last_is_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_FCS)
    else $error("out_last on a byte that is not a check sequence byte");

  // After the final byte is taken, input is held off while the tail is sent.
  a_tail_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input accepted right after the final byte of a frame");

  // Check sequence bytes leave back to back with no gap.
  a_fcs_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == KIND_FCS && !out_last
    |=> out_valid && out_kind == KIND_FCS)
    else $error("gap or foreign byte inside the check sequence");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
    && $stable(out_last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind ethernet_fcs_pad_framer efpf_checker u_efpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_kind  (out_kind),
  .out_last  (out_last)
);
